FILE: design/llca_pkg.sv
package llca_pkg;

  // Row geometry
  localparam int ROW_CELLS = 64;
  localparam int ROW_W     = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int RULE_W     = 9;
  localparam int COLS_W     = 7;

  localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS    = 2'd2;

  localparam logic [RULE_W-1:0] BIRTH_RESET   = 9'd8;
  localparam logic [RULE_W-1:0] SURVIVE_RESET = 9'd12;
  localparam logic [COLS_W-1:0] COLS_RESET    = 7'd64;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_cells;
    logic             last_row;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_cells;
    logic             last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [RULE_W-1:0] birth_rule;
    logic [RULE_W-1:0] survive_rule;
    logic [COLS_W-1:0] cols_in_use;
  } cfg_t;

  // One row to evaluate, with its neighbors above and below
  typedef struct packed {
    row_t up;
    row_t mid;
    row_t down;
    logic last;
  } job_t;

  // Zero, one or two jobs from one accepted row, in order
  typedef struct packed {
    logic [1:0] cnt;
    job_t       first;
    job_t       second;
  } push_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  // Bit c set when column c is in use
  function automatic row_t col_mask(input logic [COLS_W-1:0] cols);
    row_t mask;
    for (int c = 0; c < ROW_W; c++) begin
      mask[c] = (c < ROW_CELLS) && (COLS_W'(c) < cols);
    end
    return mask;
  endfunction

  // Next generation of job.mid; one lane per column
  function automatic row_t next_row(input job_t job, input cfg_t cfg);
    logic [ROW_W+1:0] u;
    logic [ROW_W+1:0] m;
    logic [ROW_W+1:0] d;
    row_t             mask;
    row_t             res;
    logic [3:0]       cnt;
    mask = col_mask(cfg.cols_in_use);
    // pad with dead cells on both edges; column c sits at position c+1
    u = {1'b0, job.up & mask, 1'b0};
    m = {1'b0, job.mid & mask, 1'b0};
    d = {1'b0, job.down & mask, 1'b0};
    for (int c = 0; c < ROW_W; c++) begin
      cnt = {3'b0, u[c]} + {3'b0, u[c+1]} + {3'b0, u[c+2]}
          + {3'b0, m[c]} + {3'b0, m[c+2]}
          + {3'b0, d[c]} + {3'b0, d[c+1]} + {3'b0, d[c+2]};
      res[c] = m[c+1] ? cfg.survive_rule[cnt] : cfg.birth_rule[cnt];
    end
    return res & mask;
  endfunction

endpackage

FILE: design/llca_front.sv
module llca_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  llca_pkg::in_item_t row_item,
  input  llca_pkg::cfg_t   cfg,
  output llca_pkg::push_t  push
);
  import llca_pkg::*;

  row_t above_row;
  row_t held_row;
  logic held_valid;

  row_t row_in;
  row_t above_mid;
  job_t job_held;
  job_t job_last;

  // masked incoming row
  assign row_in = row_item.row_cells & col_mask(cfg.cols_in_use);

  // row above the new row once the held row moves up
  assign above_mid = held_valid ? held_row : '0;

  assign job_held = '{up: above_row, mid: held_row, down: row_in, last: 1'b0};
  assign job_last = '{up: above_mid, mid: row_in, down: '0, last: 1'b1};

  // pack jobs in order: held row first, then bottom row
  always_comb begin
    push = '{cnt: 2'd0, first: job_held, second: job_last};
    if (accept) begin
      priority if (held_valid && row_item.last_row) begin
        push.cnt = 2'd2;
      end else if (held_valid) begin
        push.cnt = 2'd1;
      end else if (row_item.last_row) begin
        push.cnt    = 2'd1;
        push.first  = job_last;
      end else begin
        push.cnt = 2'd0;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      above_row  <= '0;
      held_row   <= '0;
      held_valid <= 1'b0;
    end else if (accept) begin
      if (row_item.last_row) begin
        above_row  <= '0;
        held_row   <= '0;
        held_valid <= 1'b0;
      end else begin
        above_row  <= above_mid;
        held_row   <= row_in;
        held_valid <= 1'b1;
      end
    end
  end

endmodule

FILE: design/llca_queue.sv
module llca_queue (
  input  logic            clk,
  input  logic            rst,
  input  llca_pkg::push_t push,
  input  logic            pop,
  output llca_pkg::head_t head,
  output logic            full
);
  import llca_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head = '{valid: (count != '0), job: entries[rd_ptr]};

  // room for two jobs is needed before taking the next row
  assign full = (count > QCNT_W'(QUEUE_DEPTH - 2));

  // storage writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push.cnt) - QCNT_W'(pop);
    end
  end

endmodule

FILE: design/llca_back.sv
module llca_back (
  input  logic                clk,
  input  logic                rst,
  input  llca_pkg::head_t     head,
  input  llca_pkg::cfg_t      cfg,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output llca_pkg::out_item_t result_item
);
  import llca_pkg::*;

  // take the head whenever the output register is free or draining
  assign pop = head.valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // neighbor count and rule lookup, registered
  always_ff @(posedge clk) begin
    if (pop) begin
      result_item.next_cells    <= next_row(head.job, cfg);
      result_item.last_of_frame <= head.job.last;
    end
  end

endmodule

FILE: design/life_like_automaton_row_step.sv
// Flow: a row's result passes the job queue and the output register after the row
//   below or a lone bottom row is taken; a bottom row's result follows a held row's.
// Throughput: one row per cycle unless row_stall; a bottom row queues two results,
//   so a frame of N rows delivers N results; results also wait on result_stall.
// Reset (rst, synchronous): clears the frame state, the job queue and the output valid;
//   rules return to birth 8 (3 neighbors), survive 12 (2 or 3), and 64 columns in use.
module life_like_automaton_row_step (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 row_valid,
  output logic                                 row_stall,
  input  llca_pkg::in_item_t                   row_item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output llca_pkg::out_item_t                  result_item,
  input  logic                                 cfg_we,
  input  logic [llca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [llca_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import llca_pkg::*;

  cfg_t  cfg;
  push_t push;
  head_t head;
  logic  full;
  logic  pop;
  logic  accept;

  assign row_stall = full;
  assign accept    = row_valid && !row_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.birth_rule   <= BIRTH_RESET;
      cfg.survive_rule <= SURVIVE_RESET;
      cfg.cols_in_use  <= COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIRTH:   cfg.birth_rule   <= cfg_data[RULE_W-1:0];
        REG_SURVIVE: cfg.survive_rule <= cfg_data[RULE_W-1:0];
        REG_COLS:    cfg.cols_in_use  <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  llca_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .row_item (row_item),
    .cfg      (cfg),
    .push     (push)
  );

  llca_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  llca_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .cfg          (cfg),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

FILE: design/llca_checker.sv
module llca_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            row_valid,
  input  logic                            row_stall,
  input  llca_pkg::in_item_t              row_item,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  llca_pkg::out_item_t             result_item,
  input  logic                            cfg_we,
  input  logic [llca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [llca_pkg::CFG_DATA_W-1:0] cfg_data
);
  import llca_pkg::*;

  // nothing is offered right after reset
  a_reset_out: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // the queue is empty after reset, so rows are taken at once
  a_reset_in: assert property (@(posedge clk) rst |=> !row_stall)
    else $error("row_stall high after reset");

  // a bottom row always leaves a result waiting once it has passed the queue
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_stall && row_item.last_row |-> ##2 result_valid)
    else $error("no result after bottom row transaction");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // and does not change
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_item))
    else $error("result changed while stalled");

endmodule

bind life_like_automaton_row_step llca_checker u_llca_checker (.*);
